// ===== hw/rtl/bthq_pkg.sv =====
// Shared types and constants for the button tap/hold qualifier.
// Used by every module under hw/rtl; depends on nothing else.
`default_nettype none

package bthq_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 20;

  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RECOVERY = 2'd2;

  localparam logic [15:0] DEBOUNCE_RST = 16'd30;
  localparam logic [15:0] HOLD_RST     = 16'd1500;
  localparam logic [19:0] RECOVERY_RST = 20'd10000;

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_TAP  = 2'd1;
  localparam logic [1:0] EV_HOLD = 2'd2;

  typedef struct packed {
    logic        pin_level;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic       recovery;
  } out_t;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] hold_ms;
    logic [19:0] recovery_ms;
  } cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bthq_cfg_regs.sv =====
// Configuration registers of the tap/hold qualifier.
// Depends on bthq_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module bthq_cfg_regs (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [bthq_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [bthq_pkg::CFG_DATA_W-1:0]    cfg_data,
  output bthq_pkg::cfg_t                          cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms <= bthq_pkg::DEBOUNCE_RST;
      cfg.hold_ms     <= bthq_pkg::HOLD_RST;
      cfg.recovery_ms <= bthq_pkg::RECOVERY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bthq_pkg::REG_DEBOUNCE: cfg.debounce_ms <= cfg_data[15:0];
        bthq_pkg::REG_HOLD:     cfg.hold_ms     <= cfg_data[15:0];
        bthq_pkg::REG_RECOVERY: cfg.recovery_ms <= cfg_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bthq_tracker.sv =====
// Button state tracker: debounce, press timing, tap/hold/recovery decisions.
// Depends on bthq_pkg; holds the per-button state and updates it once per sample.
`default_nettype none

module bthq_tracker (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire bthq_pkg::in_t   sample,
  input  wire bthq_pkg::cfg_t  cfg,
  output bthq_pkg::out_t       res
);

  logic        raw_down, raw_down_next;
  logic        stable_down, stable_down_next;
  logic        hold_done, hold_done_next;
  logic        recovery_done, recovery_done_next;
  logic [31:0] raw_change_time, raw_change_time_next;
  logic [31:0] press_start_time, press_start_time_next;

  logic        down;
  logic [31:0] steady_ms;
  logic [31:0] press_ms;
  logic        flip;
  logic        tap;
  logic        hold_fire;
  logic        rec_fire;

  always_comb begin
    down = ~sample.pin_level;

    // restart the debounce timer on any raw change
    raw_down_next        = down;
    raw_change_time_next = (down != raw_down) ? sample.now_ms : raw_change_time;
    steady_ms            = sample.now_ms - raw_change_time_next;

    flip = (down != stable_down) && (steady_ms >= {16'd0, cfg.debounce_ms});
    tap  = flip && !down && !hold_done;

    stable_down_next      = flip ? down : stable_down;
    press_start_time_next = (flip && down) ? sample.now_ms : press_start_time;
    hold_done_next        = flip ? 1'b0 : hold_done;
    recovery_done_next    = flip ? 1'b0 : recovery_done;

    press_ms  = sample.now_ms - press_start_time_next;
    hold_fire = stable_down_next && !hold_done_next && (press_ms >= {16'd0, cfg.hold_ms});
    rec_fire  = stable_down_next && !recovery_done_next &&
                (press_ms >= {12'd0, cfg.recovery_ms});

    if (hold_fire) hold_done_next = 1'b1;
    if (rec_fire)  recovery_done_next = 1'b1;

    res.event_res = hold_fire ? bthq_pkg::EV_HOLD :
                    (tap ? bthq_pkg::EV_TAP : bthq_pkg::EV_NONE);
    res.recovery  = rec_fire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_down         <= 1'b0;
      stable_down      <= 1'b0;
      hold_done        <= 1'b0;
      recovery_done    <= 1'b0;
      raw_change_time  <= '0;
      press_start_time <= '0;
    end else if (en) begin
      raw_down         <= raw_down_next;
      stable_down      <= stable_down_next;
      hold_done        <= hold_done_next;
      recovery_done    <= recovery_done_next;
      raw_change_time  <= raw_change_time_next;
      press_start_time <= press_start_time_next;
    end
  end

`ifndef NO_ASSERTIONS
  // a reported hold must latch so it cannot repeat within the press
  a_hold_latches: assert property (@(posedge clk) disable iff (rst)
    (en && res.event_res == bthq_pkg::EV_HOLD) |=> hold_done)
    else $error("hold reported but not latched");

  // a tap only comes with a release, so recovery cannot fire with it
  a_tap_no_rec: assert property (@(posedge clk) disable iff (rst)
    (en && res.event_res == bthq_pkg::EV_TAP) |-> !res.recovery)
    else $error("tap and recovery on the same sample");

  // a stable release with no earlier hold must give a tap
  a_release_tap: assert property (@(posedge clk) disable iff (rst)
    (en && stable_down && !stable_down_next && !hold_done) |->
      res.event_res == bthq_pkg::EV_TAP)
    else $error("release without tap");

  // the flags only live while the button is stably down
  a_flags_pressed: assert property (@(posedge clk) disable iff (rst)
    (hold_done || recovery_done) |-> stable_down)
    else $error("flag set while released");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/button_tap_hold_qualifier_core.sv =====
// Top level of the button tap/hold qualifier: input register, tracker, result register.
// Depends on bthq_pkg, bthq_cfg_regs and bthq_tracker.
`default_nettype none

// Takes one sample per clock (pin level, active low, plus a wrapping ms time) and
// returns exactly one result per sample: tap on a debounced release with no hold before
// it, hold once when the press reaches hold_ms, and a recovery flag once at recovery_ms.
// A sample is registered on acceptance and evaluated straight into the result register
// once that register is free. Throughput is one sample per cycle while out_ready keeps
// the result register draining; the tracker state updating once per sample is what
// sets that rate. The input side keeps accepting while a result waits, as long as the
// result register can drain. The user must write configuration through cfg_we/cfg_index/
// cfg_data only while the block is idle; the block itself does not enforce this.
module button_tap_hold_qualifier_core (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output      logic                               in_ready,
  input  wire bthq_pkg::in_t                      in_data,
  output      logic                               out_valid,
  input  wire logic                               out_ready,
  output bthq_pkg::out_t                          out_data,
  input  wire logic                               cfg_we,
  input  wire logic [bthq_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [bthq_pkg::CFG_DATA_W-1:0]    cfg_data
);

  bthq_pkg::cfg_t cfg;
  bthq_pkg::in_t  sample;
  bthq_pkg::out_t res;
  logic           sample_valid;
  logic           advance;

  // move the held sample into the result register when that register is free
  assign advance  = sample_valid && (!out_valid || out_ready);
  assign in_ready = !sample_valid || advance;

  bthq_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bthq_tracker u_tracker (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .sample (sample),
    .cfg    (cfg),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (in_ready) begin
      sample_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking bench for button_tap_hold_qualifier_core: debounce, tap, hold and recovery.
// Needs bthq_pkg and the core RTL; keeps its own tracker model to predict every result.
module tb;
  import bthq_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;  // past the register list, ignored
  localparam int IDLE_PCT       = 27;
  localparam int DRAIN_PAD      = 6;
  localparam int STALL_CYCLES   = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  in_t                    in_data   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_t                   out_data;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  button_tap_hold_qualifier_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Tracker copy: thresholds and press state as the block should hold them
  logic [15:0] trk_debounce    = DEBOUNCE_RST;
  logic [15:0] trk_hold        = HOLD_RST;
  logic [19:0] trk_recovery    = RECOVERY_RST;
  logic        trk_raw_down    = 1'b0;
  logic        trk_stable_down = 1'b0;
  logic        trk_hold_fired  = 1'b0;
  logic        trk_rec_fired   = 1'b0;
  logic [31:0] trk_raw_edge_ms = '0;
  logic [31:0] trk_press_ms    = '0;

  out_t        pending[$];
  int unsigned n_samples    = 0;
  int unsigned n_results    = 0;
  int unsigned n_taps       = 0;
  int unsigned n_holds      = 0;
  int unsigned n_recovery   = 0;
  int unsigned n_mismatch   = 0;
  int unsigned n_settings   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left   = 0;
  int          stall_asks   = 0;
  int          stall_served = 0;
  bit          steady_flow  = 1'b0;
  logic [31:0] clock_ms     = '0;

  initial begin
    forever #6 clk = ~clk;
  end

  // Advance the tracker by one pin sample and return the result it should produce
  function automatic out_t track_sample(in_t smp);
    logic        down;
    logic [31:0] span;
    out_t        res;
    down          = ~smp.pin_level;
    res.event_res = EV_NONE;
    res.recovery  = 1'b0;
    if (down != trk_raw_down) begin
      trk_raw_down    = down;
      trk_raw_edge_ms = smp.now_ms;
    end
    span = smp.now_ms - trk_raw_edge_ms;
    if (down != trk_stable_down && span >= 32'(trk_debounce)) begin
      trk_stable_down = down;
      if (down) begin
        trk_press_ms = smp.now_ms;
      end else if (!trk_hold_fired) begin
        res.event_res = EV_TAP;
      end
      trk_hold_fired = 1'b0;
      trk_rec_fired  = 1'b0;
    end
    // a release leaves stable_down low, so neither check below can fire on it
    span = smp.now_ms - trk_press_ms;
    if (trk_stable_down && !trk_hold_fired && span >= 32'(trk_hold)) begin
      trk_hold_fired = 1'b1;
      res.event_res  = EV_HOLD;
    end
    if (trk_stable_down && !trk_rec_fired && span >= 32'(trk_recovery)) begin
      trk_rec_fired = 1'b1;
      res.recovery  = 1'b1;
    end
    return res;
  endfunction

  task automatic send_sample(logic pin, logic [31:0] stamp);
    in_t smp;
    smp.pin_level = pin;
    smp.now_ms    = stamp;
    if (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < IDLE_PCT);
    end
    in_valid <= 1'b1;
    in_data  <= smp;
    do @(posedge clk); while (!in_ready);
    pending.push_back(track_sample(smp));
    n_samples++;
  endtask

  // Drain, then write all registers; upper data bits of the 16-bit ones are noise
  task automatic program_thresholds(logic [15:0] debounce, logic [15:0] hold_len,
                                    logic [19:0] recovery);
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SPARE;
    cfg_data  <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_index <= REG_DEBOUNCE;
    cfg_data  <= {4'($urandom), debounce};
    @(posedge clk);
    cfg_index <= REG_HOLD;
    cfg_data  <= {4'($urandom), hold_len};
    @(posedge clk);
    cfg_index <= REG_RECOVERY;
    cfg_data  <= recovery;
    @(posedge clk);
    cfg_we       <= 1'b0;
    trk_debounce = debounce;
    trk_hold     = hold_len;
    trk_recovery = recovery;
    n_settings++;
  endtask

  // Press/release gestures with contact bounce, plus a few stray samples
  task automatic send_gestures(int unsigned count, int unsigned step_max,
                               int unsigned bounce_max);
    int unsigned stop_at;
    logic        lvl;
    stop_at = n_samples + count;
    while (n_samples < stop_at) begin
      if ($urandom_range(0, 99) < 8) begin
        send_sample(1'($urandom), $urandom);
      end else begin
        for (int ph = 0; ph < 2; ph++) begin
          lvl = (ph == 1);
          repeat ($urandom_range(0, 3)) begin
            clock_ms += $urandom_range(0, bounce_max);
            send_sample(1'($urandom), clock_ms);
          end
          repeat ($urandom_range(1, lvl ? 4 : 10)) begin
            clock_ms += $urandom_range(0, step_max);
            send_sample(lvl, clock_ms);
          end
        end
      end
    end
  endtask

  task automatic test_reset_defaults();
    send_sample(1'b1, 32'd0);
    send_sample(1'b0, 32'd10);
    send_sample(1'b1, 32'd15);
    send_sample(1'b0, 32'd20);
    send_sample(1'b0, 32'd50);      // stable press
    send_sample(1'b0, 32'd1550);    // hold
    send_sample(1'b0, 32'd10050);   // recovery
    send_sample(1'b1, 32'd10100);
    send_sample(1'b1, 32'd10130);   // release after hold: no tap
    send_sample(1'b0, 32'd10200);
    send_sample(1'b0, 32'd10230);
    send_sample(1'b1, 32'd10300);
    send_sample(1'b1, 32'd10330);   // short press: tap
  endtask

  task automatic test_zero_thresholds();
    program_thresholds(16'd0, 16'd0, 20'd0);
    send_sample(1'b1, 32'd20000);
    send_sample(1'b0, 32'd20000);   // press, hold and recovery in one step
    send_sample(1'b1, 32'd20001);
  endtask

  task automatic test_wide_thresholds_wrap();
    program_thresholds(16'hFFFF, 16'hFFFF, 20'hFFFFF);
    send_sample(1'b0, 32'hFFFF_FFFF);
    send_sample(1'b0, 32'h0000_FFFE);   // debounce across the wrap
    send_sample(1'b0, 32'h0001_FFFD);
    send_sample(1'b0, 32'h0010_FFFD);
    send_sample(1'b1, 32'h0011_0000);
    send_sample(1'b1, 32'h0011_FFFF);
  endtask

  task automatic test_random_gestures();
    logic [15:0] rnd_debounce;
    logic [15:0] rnd_hold;
    logic [19:0] rnd_recovery;
    program_thresholds(16'd5, 16'd40, 20'd150);
    clock_ms = $urandom;
    send_gestures(200, 30, 6);
    program_thresholds(16'd0, 16'd0, 20'd0);
    send_gestures(150, 10, 2);
    program_thresholds(16'd1, 16'd1, 20'd2);
    send_gestures(150, 3, 2);
    program_thresholds(16'hFFFF, 16'hFFFF, 20'hFFFFF);
    clock_ms = 32'hFFF0_0000;
    send_gestures(200, 300000, 70000);
    program_thresholds(16'd3, 16'd20, 20'd20);
    send_gestures(150, 10, 4);
    program_thresholds(16'd10, 16'd100, 20'd50);
    send_gestures(150, 40, 12);
    repeat (3) begin
      rnd_debounce = 16'($urandom_range(0, 50));
      rnd_hold     = 16'($urandom_range(0, 500));
      rnd_recovery = 20'($urandom_range(0, 3000));
      program_thresholds(rnd_debounce, rnd_hold, rnd_recovery);
      send_gestures(100, rnd_recovery / 4 + rnd_debounce + 1, rnd_debounce + 1);
    end
  endtask

  task automatic test_steady_stream();
    steady_flow = 1'b1;
    program_thresholds(16'd30, 16'd1500, 20'd10000);
    send_gestures(250, 2500, 40);
    steady_flow = 1'b0;
  endtask

  task automatic test_output_backpressure();
    program_thresholds(16'd4, 16'd25, 20'd90);
    stall_asks++;
    send_gestures(120, 20, 5);
  endtask

  // Result sink: random ready, long hold-off on request
  always @(posedge clk) begin
    if (stall_asks != stall_served) begin
      stall_served = stall_asks;
      stall_left   = STALL_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady_flow || $urandom_range(0, 99) >= IDLE_PCT;
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (pending.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) begin
          $display("result %0d with nothing pending: event %0d recovery %0b",
                   n_results, out_data.event_res, out_data.recovery);
        end
      end else begin
        want = pending.pop_front();
        if (out_data.event_res !== want.event_res || out_data.recovery !== want.recovery) begin
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $display("result %0d: expected event %0d recovery %0b, got event %0d recovery %0b",
                     n_results, want.event_res, want.recovery,
                     out_data.event_res, out_data.recovery);
          end
        end
        if (want.event_res == EV_TAP) n_taps++;
        if (want.event_res == EV_HOLD) n_holds++;
        if (want.recovery) n_recovery++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL button_tap_hold_qualifier_core");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_zero_thresholds();
    test_wide_thresholds_wrap();
    test_random_gestures();
    test_steady_stream();
    test_output_backpressure();
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
    $display("Sent %0d pin samples over %0d threshold settings, %0d results checked.",
             n_samples, n_settings, n_results);
    $display("Results held %0d taps, %0d holds and %0d recovery flags; %0d mismatches.",
             n_taps, n_holds, n_recovery, n_mismatch);
    if (n_mismatch == 0) begin
      $display("PASS button_tap_hold_qualifier_core");
    end else begin
      $display("FAIL button_tap_hold_qualifier_core");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/bthq_pkg.sv
hw/rtl/bthq_cfg_regs.sv
hw/rtl/bthq_tracker.sv
hw/rtl/button_tap_hold_qualifier_core.sv
test/tb.sv
